@@ sv/ahke_pkg.sv @@
// Package: field widths, register codes, reset levels and key codes of the hysteresis key encoder.
package ahke_pkg;

	localparam int LEVEL_W   = 15;
	localparam int AXIS_W    = 16;
	localparam int PROD_W    = 2 * AXIS_W;
	localparam int SUM_W     = PROD_W + 2;
	localparam int BTN_W     = 7;
	localparam int NUM_FLAGS = 16;
	localparam int IDX_W     = 4;
	localparam int CFG_IDX_W = 2;
	localparam int S_DATA_W  = 136;
	localparam int M_DATA_W  = 8;

	localparam logic [LEVEL_W-1:0] MOVE_PRESS_RST     = 15'd13107;
	localparam logic [LEVEL_W-1:0] MOVE_RELEASE_RST   = 15'd8192;
	localparam logic [LEVEL_W-1:0] ANALOG_PRESS_RST   = 15'd18022;
	localparam logic [LEVEL_W-1:0] ANALOG_RELEASE_RST = 15'd11469;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MOVE_PRESS     = 2'd0,
		CFG_MOVE_RELEASE   = 2'd1,
		CFG_ANALOG_PRESS   = 2'd2,
		CFG_ANALOG_RELEASE = 2'd3
	} cfg_idx_t;

	localparam logic [IDX_W-1:0] KEY_W     = 4'd0;
	localparam logic [IDX_W-1:0] KEY_A     = 4'd1;
	localparam logic [IDX_W-1:0] KEY_S     = 4'd2;
	localparam logic [IDX_W-1:0] KEY_D     = 4'd3;
	localparam logic [IDX_W-1:0] KEY_SPACE = 4'd4;
	localparam logic [IDX_W-1:0] KEY_CTRL  = 4'd5;
	localparam logic [IDX_W-1:0] KEY_SHIFT = 4'd6;
	localparam logic [IDX_W-1:0] KEY_R     = 4'd7;
	localparam logic [IDX_W-1:0] KEY_Q     = 4'd8;
	localparam logic [IDX_W-1:0] KEY_C     = 4'd9;
	localparam logic [IDX_W-1:0] KEY_F     = 4'd10;
	localparam logic [IDX_W-1:0] KEY_ONE   = 4'd11;
	localparam logic [IDX_W-1:0] KEY_TWO   = 4'd12;
	localparam logic [IDX_W-1:0] KEY_F1    = 4'd13;
	localparam logic [IDX_W-1:0] MOUSE_L   = 4'd14;
	localparam logic [IDX_W-1:0] MOUSE_R   = 4'd15;

	localparam int BTN_A     = 0;
	localparam int BTN_B     = 1;
	localparam int BTN_X     = 2;
	localparam int BTN_Y     = 3;
	localparam int BTN_THL   = 4;
	localparam int BTN_THR   = 5;
	localparam int BTN_MENU  = 6;

	// event slot to flag index for an active poll
	function automatic logic [IDX_W-1:0] active_order(input logic [IDX_W-1:0] pos);
		logic [IDX_W-1:0] idx;
		case (pos)
			4'd0:    idx = KEY_W;
			4'd1:    idx = KEY_S;
			4'd2:    idx = KEY_D;
			4'd3:    idx = KEY_A;
			4'd4:    idx = MOUSE_L;
			4'd5:    idx = MOUSE_R;
			4'd6:    idx = KEY_SPACE;
			4'd7:    idx = KEY_CTRL;
			4'd8:    idx = KEY_R;
			4'd9:    idx = KEY_Q;
			4'd10:   idx = KEY_C;
			4'd11:   idx = KEY_SHIFT;
			4'd12:   idx = KEY_F;
			4'd13:   idx = KEY_F1;
			4'd14:   idx = KEY_ONE;
			4'd15:   idx = KEY_TWO;
			default: idx = KEY_W;
		endcase
		return idx;
	endfunction

endpackage

@@ sv/axis_hysteresis_key_encoder.sv @@
// Top level: controller poll to key and mouse transition events with hysteresis.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | one poll: tdata axes and levels, tuser active
//  m_*     | out | m_tvalid/m_tready  | one event: tdata index and pressed, tlast
//  cfg_*   | in  | cfg_we             | threshold registers, no read-back
//
// A poll passes an input register and a product register, then its events load an
// event register that drains one event per cycle into the output register when free.
// A poll causing several events holds back later polls until its events drain; polls
// with at most one event are accepted every cycle while m_tready does not stall.
// arst_n clears valid flags, held flags and the Y edge, selects slot two next and
// reloads the default thresholds.
// A stalled m_tready holds the output item and backs up through the stages.
module axis_hysteresis_key_encoder (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// move_x, move_y, lag_sine, lag_cosine, trigger_right, trigger_left,
	// grip_left, grip_right, button_bits, zero pad
	input  logic [ahke_pkg::S_DATA_W-1:0]  s_tdata,
	// active
	input  logic                           s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// output_index, pressed, zero pad
	output logic [ahke_pkg::M_DATA_W-1:0]  m_tdata,
	output logic                           m_tlast,
	input  logic                           cfg_we,
	input  logic [ahke_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ahke_pkg::LEVEL_W-1:0]   cfg_data
);

	localparam int LW = ahke_pkg::LEVEL_W;
	localparam int AW = ahke_pkg::AXIS_W;
	localparam int PW = ahke_pkg::PROD_W;
	localparam int SW = ahke_pkg::SUM_W;
	localparam int NF = ahke_pkg::NUM_FLAGS;
	localparam int XW = ahke_pkg::IDX_W;

	logic [LW-1:0] move_press_q, move_release_q, analog_press_q, analog_release_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			move_press_q     <= ahke_pkg::MOVE_PRESS_RST;
			move_release_q   <= ahke_pkg::MOVE_RELEASE_RST;
			analog_press_q   <= ahke_pkg::ANALOG_PRESS_RST;
			analog_release_q <= ahke_pkg::ANALOG_RELEASE_RST;
		end else if (cfg_we) begin
			case (ahke_pkg::cfg_idx_t'(cfg_index))
				ahke_pkg::CFG_MOVE_PRESS:     move_press_q     <= cfg_data;
				ahke_pkg::CFG_MOVE_RELEASE:   move_release_q   <= cfg_data;
				ahke_pkg::CFG_ANALOG_PRESS:   analog_press_q   <= cfg_data;
				ahke_pkg::CFG_ANALOG_RELEASE: analog_release_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1: input register
	logic                       valid_s1, active_s1;
	logic signed [AW-1:0]       mx_s1, my_s1, sn_s1, cs_s1;
	logic [LW-1:0]              trr_s1, trl_s1, grl_s1, grr_s1;
	logic [ahke_pkg::BTN_W-1:0] btn_s1;

	// stage 2: product register
	logic                       valid_s2, active_s2;
	logic signed [PW-1:0]       my_cs_s2, mx_sn_s2, mx_cs_s2, my_sn_s2;
	logic [LW-1:0]              trr_s2, trl_s2, grl_s2, grr_s2;
	logic [ahke_pkg::BTN_W-1:0] btn_s2;

	logic [NF-1:0] held_q;
	logic          slot_two_q, prev_y_q;

	logic [NF-1:0] ev_mask_q, ev_flags_q;
	logic          ev_active_q;

	logic          m_valid_q, m_last_q, m_pressed_q;
	logic [XW-1:0] m_index_q;

	logic out_free, ev_free, adv_s2, ready_s2, load_ev;

	// stage 2 evaluation
	logic signed [SW-1:0] fwd, rgt, neg_fwd, neg_rgt, thr_w, thr_s, thr_d, thr_a;
	logic [NF-1:0]        new_flags, changed, pos_mask;
	logic                 y_now, y_rise, y_fall;

	function automatic logic signed [SW-1:0] move_thr(input logic held,
		input logic [LW-1:0] rel, input logic [LW-1:0] prs);
		logic [LW-1:0] lvl;
		lvl = held ? rel : prs;
		return $signed({{(SW-2*LW){1'b0}}, lvl, {LW{1'b0}}});
	endfunction

	function automatic logic analog_on(input logic held, input logic [LW-1:0] v,
		input logic [LW-1:0] rel, input logic [LW-1:0] prs);
		return v > (held ? rel : prs);
	endfunction

	always_comb begin
		fwd = SW'(my_cs_s2) + SW'(mx_sn_s2);
		rgt = SW'(mx_cs_s2) - SW'(my_sn_s2);
		neg_fwd = -fwd;
		neg_rgt = -rgt;
		thr_w = move_thr(held_q[ahke_pkg::KEY_W], move_release_q, move_press_q);
		thr_s = move_thr(held_q[ahke_pkg::KEY_S], move_release_q, move_press_q);
		thr_d = move_thr(held_q[ahke_pkg::KEY_D], move_release_q, move_press_q);
		thr_a = move_thr(held_q[ahke_pkg::KEY_A], move_release_q, move_press_q);
		y_now  = btn_s2[ahke_pkg::BTN_Y];
		y_rise = y_now && !prev_y_q;
		y_fall = !y_now && prev_y_q;

		new_flags = held_q;
		new_flags[ahke_pkg::KEY_W] = fwd > thr_w;
		new_flags[ahke_pkg::KEY_S] = neg_fwd > thr_s;
		new_flags[ahke_pkg::KEY_D] = rgt > thr_d;
		new_flags[ahke_pkg::KEY_A] = neg_rgt > thr_a;
		new_flags[ahke_pkg::MOUSE_L] = analog_on(held_q[ahke_pkg::MOUSE_L], trr_s2,
			analog_release_q, analog_press_q);
		new_flags[ahke_pkg::MOUSE_R] = analog_on(held_q[ahke_pkg::MOUSE_R], trl_s2,
			analog_release_q, analog_press_q);
		new_flags[ahke_pkg::KEY_Q] = analog_on(held_q[ahke_pkg::KEY_Q], grl_s2,
			analog_release_q, analog_press_q);
		new_flags[ahke_pkg::KEY_C] = analog_on(held_q[ahke_pkg::KEY_C], grr_s2,
			analog_release_q, analog_press_q);
		new_flags[ahke_pkg::KEY_SPACE] = btn_s2[ahke_pkg::BTN_A];
		new_flags[ahke_pkg::KEY_CTRL]  = btn_s2[ahke_pkg::BTN_B];
		new_flags[ahke_pkg::KEY_R]     = btn_s2[ahke_pkg::BTN_X];
		new_flags[ahke_pkg::KEY_SHIFT] = btn_s2[ahke_pkg::BTN_THL];
		new_flags[ahke_pkg::KEY_F]     = btn_s2[ahke_pkg::BTN_THR];
		new_flags[ahke_pkg::KEY_F1]    = btn_s2[ahke_pkg::BTN_MENU];
		if (y_rise) begin
			if (slot_two_q) begin
				new_flags[ahke_pkg::KEY_TWO] = 1'b1;
			end else begin
				new_flags[ahke_pkg::KEY_ONE] = 1'b1;
			end
		end else if (y_fall) begin
			new_flags[ahke_pkg::KEY_ONE] = 1'b0;
			new_flags[ahke_pkg::KEY_TWO] = 1'b0;
		end
		if (!active_s2) begin
			new_flags = '0;
		end

		changed = new_flags ^ held_q;
		for (int p = 0; p < NF; p++) begin
			pos_mask[XW'(p)] = active_s2 ? changed[ahke_pkg::active_order(XW'(p))]
				: changed[XW'(p)];
		end
	end

	// event pick: lowest pending slot
	logic [XW-1:0] pick_pos, pick_idx;
	logic [NF-1:0] ev_rest;

	always_comb begin
		pick_pos = '0;
		for (int p = NF - 1; p >= 0; p--) begin
			if (ev_mask_q[XW'(p)]) begin
				pick_pos = XW'(p);
			end
		end
		pick_idx = ev_active_q ? ahke_pkg::active_order(pick_pos) : pick_pos;
		ev_rest = ev_mask_q & (ev_mask_q - NF'(1));
	end

	assign out_free = !m_valid_q || m_tready;
	assign ev_free  = (ev_mask_q == '0) || (out_free && ev_rest == '0);
	assign adv_s2   = valid_s2 && (ev_free || pos_mask == '0);
	assign load_ev  = adv_s2 && pos_mask != '0;
	assign ready_s2 = !valid_s2 || adv_s2;
	assign s_tready = !valid_s1 || ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			active_s1 <= s_tuser;
			mx_s1  <= $signed(s_tdata[15:0]);
			my_s1  <= $signed(s_tdata[31:16]);
			sn_s1  <= $signed(s_tdata[47:32]);
			cs_s1  <= $signed(s_tdata[63:48]);
			trr_s1 <= s_tdata[78:64];
			trl_s1 <= s_tdata[93:79];
			grl_s1 <= s_tdata[108:94];
			grr_s1 <= s_tdata[123:109];
			btn_s1 <= s_tdata[130:124];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s2) begin
			active_s2 <= active_s1;
			my_cs_s2  <= PW'(my_s1) * PW'(cs_s1);
			mx_sn_s2  <= PW'(mx_s1) * PW'(sn_s1);
			mx_cs_s2  <= PW'(mx_s1) * PW'(cs_s1);
			my_sn_s2  <= PW'(my_s1) * PW'(sn_s1);
			trr_s2    <= trr_s1;
			trl_s2    <= trl_s1;
			grl_s2    <= grl_s1;
			grr_s2    <= grr_s1;
			btn_s2    <= btn_s1;
		end
	end

	// poll state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q     <= '0;
			slot_two_q <= 1'b1;
			prev_y_q   <= 1'b0;
		end else if (adv_s2) begin
			held_q <= new_flags;
			if (active_s2) begin
				prev_y_q <= y_now;
				if (y_fall) begin
					slot_two_q <= !slot_two_q;
				end
			end
		end
	end

	// event register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_mask_q <= '0;
		end else if (load_ev) begin
			ev_mask_q <= pos_mask;
		end else if (out_free && ev_mask_q != '0) begin
			ev_mask_q <= ev_rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load_ev) begin
			ev_flags_q  <= new_flags;
			ev_active_q <= active_s2;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= ev_mask_q != '0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && ev_mask_q != '0) begin
			m_index_q   <= pick_idx;
			m_pressed_q <= ev_flags_q[pick_idx];
			m_last_q    <= ev_rest == '0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tlast  = m_last_q;
	assign m_tdata  = {{(ahke_pkg::M_DATA_W - XW - 1){1'b0}}, m_pressed_q, m_index_q};

endmodule
